FILE: rtl/core/wom_pkg.sv
// ----------------------------------------------------------------------------
// wom_pkg: shared types and constants of the wavetable oscillator mixer
// Holds the configuration record, register indexes and fixed levels.
// ----------------------------------------------------------------------------
`default_nettype none

package wom_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W     = 16;
  localparam int PHASE_STEP_W = 26;
  localparam int PULSE_W      = 11;
  localparam int GAIN_W       = 16;

  // Peak waveform level and the Q1.15 fraction width of the gain.
  localparam int PEAK_LEVEL  = 32767;
  localparam int GAIN_FRAC_W = 15;

  // Depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  // Register reset values.
  localparam logic [PULSE_W-1:0] DUTY_LIMIT_RST = 11'd512;
  localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd6554;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_WAVEFORM   = 3'd1,
    REG_PHASE_STEP = 3'd2,
    REG_PULSE_W    = 3'd3,
    REG_GAIN       = 3'd4
  } wom_reg_t;

  // Waveform select codes.
  localparam logic WAVE_TRIANGLE = 1'b0;
  localparam logic WAVE_PULSE    = 1'b1;

  // Configuration record handed to the front and the back end.
  typedef struct packed {
    logic                    enable;
    logic                    waveform;
    logic [PHASE_STEP_W-1:0] phase_step;
    logic [PULSE_W-1:0]      duty_limit;
    logic [GAIN_W-1:0]       gain;
  } wom_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/wom_in_if.sv
// ----------------------------------------------------------------------------
// wom_in_if: input sample channel
// Carries valid, ready and one signed mix sample per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface wom_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mix_in;

  modport source (output valid, output mix_in, input ready);
  modport sink   (input valid, input mix_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/wom_out_if.sv
// ----------------------------------------------------------------------------
// wom_out_if: result sample channel
// Carries valid, ready and one signed mixed sample per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface wom_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mix_out;

  modport source (output valid, output mix_out, input ready);
  modport sink   (input valid, input mix_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/wom_front.sv
// ----------------------------------------------------------------------------
// wom_front: request intake and phase accumulator
// Accepts samples, advances the phase when enabled and queues the sample
// together with its table index and an active flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wom_front #(
  parameter int TABLE_LENGTH        = 1024,
  parameter int PHASE_FRACTION_BITS = 16,
  localparam int IDX_W  = $clog2(TABLE_LENGTH),
  localparam int ITEM_W = 1 + IDX_W + wom_pkg::SAMPLE_W
) (
  input  wire                   clk,
  input  wire                   rst_n,
  wom_in_if.sink                in_stream,
  input  wom_pkg::wom_cfg_t     cfg,
  input  wire                   q_full,
  output logic                  q_push,
  output logic [ITEM_W-1:0]     q_data
);

  localparam int ACC_W = IDX_W + PHASE_FRACTION_BITS;
  localparam int SUM_W = (ACC_W > wom_pkg::PHASE_STEP_W) ? ACC_W : wom_pkg::PHASE_STEP_W;

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [SUM_W-1:0] acc_sum;

  // The table length is a power of two, so the modulo is a plain truncation.
  assign acc_sum = SUM_W'(acc_r) + SUM_W'(cfg.phase_step);
  assign acc_nxt = acc_sum[ACC_W-1:0];

  assign in_stream.ready = !q_full;
  assign q_push          = in_stream.valid && !q_full;
  assign q_data          = {cfg.enable, acc_nxt[ACC_W-1:PHASE_FRACTION_BITS], in_stream.mix_in};

  // The phase moves only for requests taken while enabled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (q_push && cfg.enable) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/wom_queue.sv
// ----------------------------------------------------------------------------
// wom_queue: small FIFO between the front and the back end
// Lets the intake keep taking requests while the back end is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module wom_queue #(
  parameter int WIDTH = 27
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire [WIDTH-1:0]  push_data,
  output logic             full,
  input  wire              pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = wom_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Occupancy never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");

  // Nothing is popped from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from empty queue");

  // A lone push raises the occupancy by one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("push did not raise occupancy");

endmodule

`default_nettype wire

FILE: rtl/core/wom_back.sv
// ----------------------------------------------------------------------------
// wom_back: waveform, gain and mix pipeline
// Three stages: waveform value, gain product, then truncation toward zero,
// saturation and the 16-bit add into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wom_back #(
  parameter int TABLE_LENGTH = 1024,
  localparam int IDX_W  = $clog2(TABLE_LENGTH),
  localparam int ITEM_W = 1 + IDX_W + wom_pkg::SAMPLE_W
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wom_pkg::wom_cfg_t  cfg,
  input  wire                q_valid,
  input  wire [ITEM_W-1:0]   q_data,
  output logic               q_pop,
  wom_out_if.source          out_stream
);

  localparam int SW     = wom_pkg::SAMPLE_W;
  localparam int SLOPE  = (4 * wom_pkg::PEAK_LEVEL) / TABLE_LENGTH;
  localparam int PROD_W = SW + wom_pkg::GAIN_W + 1;
  localparam int Q_W    = PROD_W - wom_pkg::GAIN_FRAC_W;

  // Queue entry fields.
  logic                 it_active;
  logic [IDX_W-1:0]     it_idx;
  logic signed [SW-1:0] it_mix;

  // Stage registers.
  logic                   s1_v_r;
  logic signed [SW-1:0]   s1_val_r;
  logic signed [SW-1:0]   s1_mix_r;
  logic                   s2_v_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [SW-1:0]   s2_mix_r;
  logic                   out_v_r;
  logic signed [SW-1:0]   out_mix_r;

  // Stage readiness.
  logic rdy1, rdy2, rdy3;

  // Stage 1 datapath.
  logic [IDX_W-1:0]     tri_t;
  logic [IDX_W-1:0]     tri_d;
  logic [17:0]          tri_mag;
  logic signed [17:0]   tri_val;
  logic                 pulse_hi;
  logic signed [SW-1:0] wave_val;

  // Stage 2 datapath.
  logic signed [PROD_W-1:0] prod;

  // Stage 3 datapath.
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [Q_W-1:0]    scaled;
  logic signed [SW-1:0]     scaled_sat;

  assign {it_active, it_idx, it_mix} = q_data;

  assign rdy3  = !out_v_r || out_stream.ready;
  assign rdy2  = !s2_v_r || rdy3;
  assign rdy1  = !s1_v_r || rdy2;
  assign q_pop = q_valid && rdy1;

  // Triangle: slope times distance of the index, less a quarter table, from the half-table point, less the peak.
  always_comb begin
    tri_t = it_idx - IDX_W'(TABLE_LENGTH / 4);
    if (tri_t[IDX_W-1]) begin
      tri_d = tri_t - IDX_W'(TABLE_LENGTH / 2);
    end else begin
      tri_d = IDX_W'(TABLE_LENGTH / 2) - tri_t;
    end
    tri_mag  = 18'(SLOPE) * 18'(tri_d);
    tri_val  = $signed(tri_mag) - 18'sd32767;
    pulse_hi = (17'(it_idx) <= 17'(cfg.duty_limit));
    // An inactive sample gets a zero value so it passes through unchanged.
    if (!it_active) begin
      wave_val = '0;
    end else if (cfg.waveform == wom_pkg::WAVE_PULSE) begin
      wave_val = pulse_hi ? SW'(wom_pkg::PEAK_LEVEL) : '0;
    end else begin
      wave_val = tri_val[SW-1:0];
    end
  end

  // Gain product, Q1.15 unsigned gain.
  assign prod = s1_val_r * $signed({1'b0, cfg.gain});

  // Truncate toward zero, then clamp to the sample range.
  always_comb begin
    prod_adj = s2_prod_r[PROD_W-1]
             ? s2_prod_r + PROD_W'((1 << wom_pkg::GAIN_FRAC_W) - 1)
             : s2_prod_r;
    scaled   = prod_adj[PROD_W-1:wom_pkg::GAIN_FRAC_W];
    if (scaled > Q_W'(32767)) begin
      scaled_sat = 16'sh7FFF;
    end else if (scaled < -Q_W'(32768)) begin
      scaled_sat = 16'sh8000;
    end else begin
      scaled_sat = scaled[SW-1:0];
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r  <= q_valid;
      if (rdy2) s2_v_r  <= s1_v_r;
      if (rdy3) out_v_r <= s2_v_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (rdy1 && q_valid) begin
      s1_val_r <= wave_val;
      s1_mix_r <= it_mix;
    end
    if (rdy2 && s1_v_r) begin
      s2_prod_r <= prod;
      s2_mix_r  <= s1_mix_r;
    end
    if (rdy3 && s2_v_r) begin
      out_mix_r <= s2_mix_r + scaled_sat;
    end
  end

  assign out_stream.valid   = out_v_r;
  assign out_stream.mix_out = out_mix_r;

endmodule

`default_nettype wire

FILE: rtl/core/wavetable_oscillator_mixer.sv
// ----------------------------------------------------------------------------
// wavetable_oscillator_mixer: DDS oscillator added into a sample stream
// Top level with the register file, intake, queue and mix pipeline.
// ----------------------------------------------------------------------------
// The block takes one signed 16-bit sample per cycle while the queue has
// room and returns one mixed sample per request, in order. A sample is
// accepted whenever the two-entry queue behind the intake has room; the queue
// entry is written at the accepting edge, then the result passes the waveform,
// gain-multiply and mix stage registers before it is presented on the output,
// and a full pipeline sustains one sample per clock while the output is ready.
// The phase accumulator add is the recurrence that sets this rate.
// TABLE_LENGTH must be a power of two. Registers are written over the APB
// port at byte address 4*i and should be changed only while no sample is in
// flight.
`default_nettype none

module wavetable_oscillator_mixer #(
  parameter int TABLE_LENGTH        = 1024,
  parameter int PHASE_FRACTION_BITS = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  wom_in_if.sink       in_stream,
  wom_out_if.source    out_stream,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [4:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int IDX_W  = $clog2(TABLE_LENGTH);
  localparam int ITEM_W = 1 + IDX_W + wom_pkg::SAMPLE_W;

  wom_pkg::wom_cfg_t cfg_r;
  wom_pkg::wom_reg_t reg_sel;
  logic              wr_en;

  logic              q_push;
  logic [ITEM_W-1:0] q_push_data;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  logic [ITEM_W-1:0] q_data;

  assign pready  = 1'b1;
  assign reg_sel = wom_pkg::wom_reg_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable     <= 1'b0;
      cfg_r.waveform   <= wom_pkg::WAVE_TRIANGLE;
      cfg_r.phase_step <= '0;
      cfg_r.duty_limit <= wom_pkg::DUTY_LIMIT_RST;
      cfg_r.gain       <= wom_pkg::GAIN_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        wom_pkg::REG_ENABLE:     cfg_r.enable     <= pwdata[0];
        wom_pkg::REG_WAVEFORM:   cfg_r.waveform   <= pwdata[0];
        wom_pkg::REG_PHASE_STEP: cfg_r.phase_step <= pwdata[wom_pkg::PHASE_STEP_W-1:0];
        wom_pkg::REG_PULSE_W:    cfg_r.duty_limit <= pwdata[wom_pkg::PULSE_W-1:0];
        wom_pkg::REG_GAIN:       cfg_r.gain       <= pwdata[wom_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_sel)
      wom_pkg::REG_ENABLE:     prdata = 32'(cfg_r.enable);
      wom_pkg::REG_WAVEFORM:   prdata = 32'(cfg_r.waveform);
      wom_pkg::REG_PHASE_STEP: prdata = 32'(cfg_r.phase_step);
      wom_pkg::REG_PULSE_W:    prdata = 32'(cfg_r.duty_limit);
      wom_pkg::REG_GAIN:       prdata = 32'(cfg_r.gain);
      default:                 prdata = '0;
    endcase
  end

  // Intake and phase accumulator.
  wom_front #(
    .TABLE_LENGTH        (TABLE_LENGTH),
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  // Decoupling queue.
  wom_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  // Waveform, gain and mix pipeline.
  wom_back #(
    .TABLE_LENGTH (TABLE_LENGTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_stream (out_stream)
  );

endmodule

`default_nettype wire
